// ===== design/tbrl_pkg.sv =====
`timescale 1ns / 1ps

package tbrl_pkg;

   localparam int TABLE_ENTRIES = 32;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam int KEY_W = 32;
   localparam int TIME_W = 32;
   localparam int TOK_W = 8;
   localparam int BLK_W = 32;
   localparam int WIN_W = 32;
   localparam int PROD_W = TIME_W + TOK_W;
   localparam int DIV_CNT_W = $clog2(PROD_W + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int Q_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int APB_ADDR_W = 3;
   localparam int APB_DATA_W = 32;

   localparam logic [TOK_W-1:0] CAP_RESET = TOK_W'(50);
   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(60000);

   typedef enum logic [0:0] {
      REG_CAPACITY = 1'b0,
      REG_WINDOW = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      OP_CHECK = 2'd0,
      OP_QUERY = 2'd1,
      OP_REFILL = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_ALLOWED = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL = 2'd2,
      STAT_DONE = 2'd3
   } status_type;

   typedef struct packed {
      op_type op;
      logic [KEY_W-1:0] key;
      logic [TIME_W-1:0] now;
   } cmd_type;

   typedef struct packed {
      logic [TOK_W-1:0] tokens;
      logic [TIME_W-1:0] last_refill;
      logic [BLK_W-1:0] blocked;
   } entry_type;

   typedef struct packed {
      logic valid;
      cmd_type cmd;
   } queue_out_type;

endpackage

// ===== design/tbrl_req_if.sv =====
`timescale 1ns / 1ps

interface tbrl_req_if
   import tbrl_pkg::*;
   ();
   logic valid;
   logic ready;
   logic [1:0] op;
   logic [KEY_W-1:0] endpoint_key;
   logic [TIME_W-1:0] now_ms;

   modport source (output valid, output op, output endpoint_key, output now_ms, input ready);
   modport sink (input valid, input op, input endpoint_key, input now_ms, output ready);
endinterface

// ===== design/tbrl_rsp_if.sv =====
`timescale 1ns / 1ps

interface tbrl_rsp_if
   import tbrl_pkg::*;
   ();
   logic valid;
   logic ready;
   logic [1:0] status;
   logic [BLK_W-1:0] blocked_total;
   logic [TOK_W-1:0] tokens_left;

   modport source (output valid, output status, output blocked_total, output tokens_left,
                   input ready);
   modport sink (input valid, input status, input blocked_total, input tokens_left,
                 output ready);
endinterface

// ===== design/tbrl_ram.sv =====
`timescale 1ns / 1ps

module tbrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic clock,
   input  logic we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/tbrl_div.sv =====
`timescale 1ns / 1ps

module tbrl_div
   import tbrl_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [PROD_W-1:0] dividend,
   input  logic [WIN_W-1:0] divisor,
   output logic done,
   output logic [PROD_W-1:0] quotient
);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [WIN_W:0] rem_ff, rem_in;
   logic [WIN_W-1:0] div_ff, div_in;
   logic [WIN_W:0] rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      rem_sh = {rem_ff[WIN_W-1:0], quo_ff[PROD_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
      end else if (busy_ff) begin
         // one quotient bit per cycle, restoring
         if (rem_sh >= {1'b0, div_ff}) begin
            rem_in = rem_sh - {1'b0, div_ff};
            quo_in = {quo_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[PROD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(PROD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== design/tbrl_front.sv =====
`timescale 1ns / 1ps

module tbrl_front
   import tbrl_pkg::*;
(
   input  logic clock,
   input  logic reset,
   tbrl_req_if.sink req_bus,
   input  logic cmd_pop,
   output queue_out_type queue_out
);

   cmd_type q_ff [QUEUE_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic push;
   logic pop;
   cmd_type new_cmd;

   assign req_bus.ready = (count_ff < Q_CNT_W'(QUEUE_DEPTH));
   assign push = req_bus.valid && req_bus.ready;
   assign pop = cmd_pop && (count_ff != '0);

   // classify the request; the unused op code becomes a no-op
   always_comb begin
      new_cmd.key = req_bus.endpoint_key;
      new_cmd.now = req_bus.now_ms;
      case (req_bus.op)
         OP_CHECK: new_cmd.op = OP_CHECK;
         OP_QUERY: new_cmd.op = OP_QUERY;
         OP_REFILL: new_cmd.op = OP_REFILL;
         default: new_cmd.op = OP_NONE;
      endcase
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   assign queue_out.valid = (count_ff != '0);
   assign queue_out.cmd = q_ff[rd_ptr_ff];

endmodule

// ===== design/tbrl_back.sv =====
`timescale 1ns / 1ps

module tbrl_back
   import tbrl_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  queue_out_type queue_out,
   output logic cmd_pop,
   input  logic [TOK_W-1:0] capacity,
   input  logic [WIN_W-1:0] window,
   tbrl_rsp_if.source rsp_bus
);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_READ = 7'b0000010,
      S_CMP = 7'b0000100,
      S_MUL = 7'b0001000,
      S_DIV = 7'b0010000,
      S_UPD = 7'b0100000,
      S_SWEEP = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] used_ff, used_in;
   cmd_type cmd_ff, cmd_in;
   entry_type ent_ff, ent_in;

   logic rsp_valid_ff, rsp_valid_in;
   status_type status_ff, status_in;
   logic [BLK_W-1:0] blocked_ff, blocked_in;
   logic [TOK_W-1:0] tokens_ff, tokens_in;

   logic key_we;
   logic [IDX_W-1:0] key_waddr;
   logic [KEY_W-1:0] rd_key;
   logic st_we;
   entry_type st_wdata;
   entry_type rd_ent;

   logic div_start;
   logic div_done;
   logic [PROD_W-1:0] dividend;
   logic [WIN_W-1:0] divisor;
   logic [PROD_W-1:0] gain;
   logic [PROD_W:0] sum;
   logic [TOK_W-1:0] refilled;
   logic [TIME_W-1:0] elapsed;

   tbrl_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
      .clock(clock),
      .we(key_we),
      .waddr(key_waddr),
      .wdata(cmd_ff.key),
      .raddr(idx_ff[IDX_W-1:0]),
      .rdata(rd_key)
   );

   tbrl_ram #(.WIDTH($bits(entry_type)), .DEPTH(TABLE_ENTRIES)) u_entry_ram (
      .clock(clock),
      .we(st_we),
      .waddr(idx_ff[IDX_W-1:0]),
      .wdata(st_wdata),
      .raddr(idx_ff[IDX_W-1:0]),
      .rdata(rd_ent)
   );

   assign elapsed = cmd_ff.now - ent_ff.last_refill;
   assign dividend = PROD_W'(elapsed) * PROD_W'(capacity);
   assign divisor = (window == '0) ? WIN_W'(1) : window;
   assign div_start = (state_ff == S_MUL);

   tbrl_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(dividend),
      .divisor(divisor),
      .done(div_done),
      .quotient(gain)
   );

   // add the refill and cap it; the cap applies only when tokens are added
   always_comb begin
      sum = (PROD_W + 1)'(ent_ff.tokens) + (PROD_W + 1)'(gain);
      if (sum > (PROD_W + 1)'(capacity)) begin
         refilled = capacity;
      end else begin
         refilled = sum[TOK_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      used_in = used_ff;
      cmd_in = cmd_ff;
      ent_in = ent_ff;
      cmd_pop = 1'b0;
      key_we = 1'b0;
      key_waddr = used_ff[IDX_W-1:0];
      st_we = 1'b0;
      st_wdata = ent_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      status_in = status_ff;
      blocked_in = blocked_ff;
      tokens_in = tokens_ff;

      case (state_ff)
         S_IDLE: begin
            if (queue_out.valid && (!rsp_valid_ff || rsp_bus.ready)) begin
               cmd_pop = 1'b1;
               cmd_in = queue_out.cmd;
               idx_in = '0;
               case (queue_out.cmd.op)
                  OP_CHECK, OP_QUERY: state_in = S_READ;
                  OP_REFILL: state_in = S_SWEEP;
                  default: begin
                     rsp_valid_in = 1'b1;
                     status_in = STAT_DONE;
                     blocked_in = '0;
                     tokens_in = '0;
                  end
               endcase
            end
         end
         S_READ: begin
            if (idx_ff == used_ff) begin
               // key not in the table
               state_in = S_IDLE;
               if (cmd_ff.op == OP_CHECK && used_ff < CNT_W'(TABLE_ENTRIES)) begin
                  key_we = 1'b1;
                  used_in = used_ff + 1'b1;
                  ent_in.tokens = capacity;
                  ent_in.last_refill = cmd_ff.now;
                  ent_in.blocked = '0;
                  state_in = S_MUL;
               end else begin
                  rsp_valid_in = 1'b1;
                  status_in = (cmd_ff.op == OP_CHECK) ? STAT_FULL : STAT_DONE;
                  blocked_in = '0;
                  tokens_in = '0;
               end
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (rd_key == cmd_ff.key) begin
               if (cmd_ff.op == OP_CHECK) begin
                  ent_in = rd_ent;
                  state_in = S_MUL;
               end else begin
                  rsp_valid_in = 1'b1;
                  status_in = STAT_DONE;
                  blocked_in = rd_ent.blocked;
                  tokens_in = '0;
                  state_in = S_IDLE;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_MUL: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            st_wdata = ent_ff;
            if (gain != '0) begin
               st_wdata.tokens = refilled;
               st_wdata.last_refill = cmd_ff.now;
            end
            if (st_wdata.tokens != '0) begin
               st_wdata.tokens = st_wdata.tokens - 1'b1;
               status_in = STAT_ALLOWED;
            end else begin
               st_wdata.blocked = ent_ff.blocked + 1'b1;
               status_in = STAT_EMPTY;
            end
            st_we = 1'b1;
            rsp_valid_in = 1'b1;
            blocked_in = st_wdata.blocked;
            tokens_in = st_wdata.tokens;
            state_in = S_IDLE;
         end
         S_SWEEP: begin
            if (idx_ff == used_ff) begin
               rsp_valid_in = 1'b1;
               status_in = STAT_DONE;
               blocked_in = '0;
               tokens_in = '0;
               state_in = S_IDLE;
            end else begin
               st_we = 1'b1;
               st_wdata.tokens = capacity;
               st_wdata.last_refill = cmd_ff.now;
               st_wdata.blocked = '0;
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
         used_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         used_ff <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      ent_ff <= ent_in;
      status_ff <= status_in;
      blocked_ff <= blocked_in;
      tokens_ff <= tokens_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.status = status_ff;
   assign rsp_bus.blocked_total = blocked_ff;
   assign rsp_bus.tokens_left = tokens_ff;

endmodule

// ===== design/token_bucket_rate_limiter_table_top.sv =====
`timescale 1ns / 1ps

// Per-key token bucket table with up to 32 buckets, allocated in order of first use.
// Requests enter a two-deep queue and are then served one at a time. A check walks
// the active keys entry by entry (registered table read, then compare), then forms
// the elapsed-time product and runs the bit-serial divider that turns it into
// refilled tokens before the entry is updated. A query walks the entries with the
// same read and compare; a refill rewrites each active entry in turn. Each request
// gives exactly one response, held in an output register until taken. No clearing
// pass runs after reset. Capacity and window sit at byte addresses 0 and 4 of the
// APB port; the user must write them only while no request is in flight, as the
// block itself does not enforce it; a window of 0 acts as 1.
module token_bucket_rate_limiter_table_top
   import tbrl_pkg::*;
(
   input  logic clock,
   input  logic reset,
   tbrl_req_if.sink req_bus,
   tbrl_rsp_if.source rsp_bus,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [APB_ADDR_W-1:0] paddr,
   input  logic [APB_DATA_W-1:0] pwdata,
   output logic [APB_DATA_W-1:0] prdata,
   output logic pready
);

   logic [TOK_W-1:0] capacity_ff, capacity_in;
   logic [WIN_W-1:0] window_ff, window_in;
   logic csr_write;
   reg_index_type csr_index;
   queue_out_type queue_out;
   logic cmd_pop;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = reg_index_type'(paddr[2]);

   always_comb begin
      capacity_in = capacity_ff;
      window_in = window_ff;
      if (csr_write) begin
         case (csr_index)
            REG_CAPACITY: capacity_in = pwdata[TOK_W-1:0];
            REG_WINDOW: window_in = pwdata[WIN_W-1:0];
            default: begin
               capacity_in = capacity_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_CAPACITY: prdata = APB_DATA_W'(capacity_ff);
         REG_WINDOW: prdata = APB_DATA_W'(window_ff);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
         window_ff <= WINDOW_RESET;
      end else begin
         capacity_ff <= capacity_in;
         window_ff <= window_in;
      end
   end

   tbrl_front u_front (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .cmd_pop(cmd_pop),
      .queue_out(queue_out)
   );

   tbrl_back u_back (
      .clock(clock),
      .reset(reset),
      .queue_out(queue_out),
      .cmd_pop(cmd_pop),
      .capacity(capacity_ff),
      .window(window_ff),
      .rsp_bus(rsp_bus)
   );

endmodule
